[sv/ukl_pkg.sv]
// Shared types and constants for the unique-key list table.
`default_nettype none

package ukl_pkg;

  localparam int UKL_TABLE_DEPTH = 256;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } ukl_op_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_DUPLICATE = 3'd2,
    STS_FULL      = 3'd3,
    STS_RANGE     = 3'd4
  } ukl_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_READ,
    ST_RESP
  } ukl_state_t;

  typedef struct packed {
    ukl_status_t  status;
    logic [15:0]  found_handle;
    logic [31:0]  found_key;
    logic [7:0]   found_position;
    logic [8:0]   entry_total;
  } ukl_result_t;

endpackage

`default_nettype wire

[sv/unique_key_list_table.sv]
// Top level of the unique-key list table: sequencer, entry store and output register.
//
//  channel  direction  handshake                     payload
//  in_      input      in_valid / in_ready           opcode, song_key, song_handle, position
//  out_     output     out_valid / out_ready         status, found_handle, found_key,
//                                                    found_position, entry_total
//
// Lookup, insert and delete scan the stored entries in order, one entry per cycle through
// one comparator fed by the single read port of the entry store; a delete that hits then
// shifts every later entry down one place. A read in range fetches the entry at its
// position, else a range status; results wait while the output register is full.
// Reset clears the entry count and the control state; the store itself is not cleared.
// A new request is taken while the previous result still waits in the output register.
`default_nettype none

module unique_key_list_table import ukl_pkg::*; #(
  parameter int TABLE_DEPTH = UKL_TABLE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_song_key,
  input  wire logic [15:0] in_song_handle,
  input  wire logic [7:0]  in_position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  out_status,
  output logic      [15:0] out_found_handle,
  output logic      [31:0] out_found_key,
  output logic      [7:0]  out_found_position,
  output logic      [8:0]  out_entry_total
);

  localparam int IdxW = $clog2(TABLE_DEPTH);

  ukl_result_t     res;
  logic            res_valid;
  logic            res_ready;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [31:0]     mem_wkey;
  logic [15:0]     mem_whandle;
  logic [IdxW-1:0] mem_raddr;
  logic [31:0]     mem_rkey;
  logic [15:0]     mem_rhandle;

  logic            out_valid_r, out_valid_nxt;
  ukl_result_t     out_res_r;

  ukl_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_song_key    (in_song_key),
    .in_song_handle (in_song_handle),
    .in_position    (in_position),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wkey       (mem_wkey),
    .mem_whandle    (mem_whandle),
    .mem_raddr      (mem_raddr),
    .mem_rkey       (mem_rkey),
    .mem_rhandle    (mem_rhandle)
  );

  ukl_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wkey    (mem_wkey),
    .whandle (mem_whandle),
    .raddr   (mem_raddr),
    .rkey    (mem_rkey),
    .rhandle (mem_rhandle)
  );

  // The output register frees as the consumer takes its result.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_found_handle   = out_res_r.found_handle;
  assign out_found_key      = out_res_r.found_key;
  assign out_found_position = out_res_r.found_position;
  assign out_entry_total    = out_res_r.entry_total;

endmodule

`default_nettype wire

[sv/ukl_mem.sv]
// Entry store: key and handle memory with one write port and a registered read port.
`default_nettype none

module ukl_mem import ukl_pkg::*; #(
  parameter int TABLE_DEPTH = UKL_TABLE_DEPTH,
  localparam int IdxW = $clog2(TABLE_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IdxW-1:0] waddr,
  input  wire logic [31:0]     wkey,
  input  wire logic [15:0]     whandle,
  input  wire logic [IdxW-1:0] raddr,
  output logic      [31:0]     rkey,
  output logic      [15:0]     rhandle
);

  logic [31:0] key_mem    [TABLE_DEPTH];
  logic [15:0] handle_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]    <= wkey;
      handle_mem[waddr] <= whandle;
    end
    rkey    <= key_mem[raddr];
    rhandle <= handle_mem[raddr];
  end

endmodule

`default_nettype wire

[sv/ukl_ctrl.sv]
// Sequencer: linear key search, append, shift-down delete and positional read.
`default_nettype none

module ukl_ctrl import ukl_pkg::*; #(
  parameter int TABLE_DEPTH = UKL_TABLE_DEPTH,
  localparam int IdxW = $clog2(TABLE_DEPTH),
  localparam int CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_opcode,
  input  wire logic [31:0]     in_song_key,
  input  wire logic [15:0]     in_song_handle,
  input  wire logic [7:0]      in_position,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output ukl_result_t          res,
  output logic                 mem_we,
  output logic      [IdxW-1:0] mem_waddr,
  output logic      [31:0]     mem_wkey,
  output logic      [15:0]     mem_whandle,
  output logic      [IdxW-1:0] mem_raddr,
  input  wire logic [31:0]     mem_rkey,
  input  wire logic [15:0]     mem_rhandle
);

  localparam int XW = (CntW > 8) ? CntW : 8;
  localparam int PW = (IdxW > 8) ? IdxW : 8;
  localparam int TW = (CntW > 9) ? CntW : 9;

  ukl_state_t      state_r, state_nxt;
  ukl_op_t         op_r, op_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [15:0]     handle_r, handle_nxt;
  logic [CntW-1:0] rd_idx_r, rd_idx_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IdxW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  ukl_status_t     status_r, status_nxt;
  logic [15:0]     fhandle_r, fhandle_nxt;
  logic [31:0]     fkey_r, fkey_nxt;
  logic [7:0]      fpos_r, fpos_nxt;

  logic            accept;
  logic            key_hit;
  logic            scan_done;
  logic            is_full;
  logic [XW-1:0]   pos_x;
  logic            pos_in_range;
  logic [PW-1:0]   hit_pos_wide;
  logic [TW-1:0]   total_wide;

  // The one comparator: each cycle it checks the entry read in the previous cycle.
  assign accept       = in_valid && in_ready;
  assign key_hit      = cmp_vld_r && (mem_rkey == key_r);
  assign scan_done    = (rd_idx_r == count_r);
  assign is_full      = (count_r == CntW'(TABLE_DEPTH));
  assign pos_x        = XW'(in_position);
  assign pos_in_range = (pos_x < XW'(count_r));
  assign hit_pos_wide = PW'(cmp_idx_r);
  assign total_wide   = TW'(count_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);

  always_comb begin
    res.status         = status_r;
    res.found_handle   = fhandle_r;
    res.found_key      = fkey_r;
    res.found_position = fpos_r;
    res.entry_total    = total_wide[8:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (ukl_op_t'(in_opcode) == OP_READ) begin
            state_nxt = pos_in_range ? ST_READ : ST_RESP;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (key_hit) begin
          state_nxt = (op_r == OP_DELETE) ? ST_SHIFT : ST_RESP;
        end else if (scan_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_SHIFT: begin
        if (scan_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt      = op_r;
    key_nxt     = key_r;
    handle_nxt  = handle_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    fhandle_nxt = fhandle_r;
    fkey_nxt    = fkey_r;
    fpos_nxt    = fpos_r;
    mem_we      = 1'b0;
    mem_waddr   = cmp_idx_r - IdxW'(1);
    mem_wkey    = mem_rkey;
    mem_whandle = mem_rhandle;
    mem_raddr   = rd_idx_r[IdxW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        mem_raddr = pos_x[IdxW-1:0];
        if (accept) begin
          op_nxt      = ukl_op_t'(in_opcode);
          key_nxt     = in_song_key;
          handle_nxt  = in_song_handle;
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          fhandle_nxt = '0;
          fkey_nxt    = '0;
          fpos_nxt    = '0;
          if (ukl_op_t'(in_opcode) == OP_READ && pos_in_range) begin
            status_nxt = STS_OK;
            fpos_nxt   = in_position;
          end else if (ukl_op_t'(in_opcode) == OP_READ) begin
            status_nxt = STS_RANGE;
          end
        end
      end
      ST_SEARCH: begin
        if (key_hit) begin
          fhandle_nxt = mem_rhandle;
          fkey_nxt    = mem_rkey;
          fpos_nxt    = hit_pos_wide[7:0];
          unique case (op_r)
            OP_INSERT: status_nxt = STS_DUPLICATE;
            OP_DELETE: begin
              status_nxt  = STS_OK;
              rd_idx_nxt  = CntW'(cmp_idx_r) + CntW'(1);
              cmp_vld_nxt = 1'b0;
            end
            OP_LOOKUP, OP_READ: status_nxt = STS_OK;
            default: status_nxt = STS_OK;
          endcase
        end else if (scan_done) begin
          cmp_vld_nxt = 1'b0;
          if (op_r == OP_INSERT && is_full) begin
            status_nxt = STS_FULL;
          end else if (op_r == OP_INSERT) begin
            status_nxt  = STS_OK;
            mem_we      = 1'b1;
            mem_waddr   = count_r[IdxW-1:0];
            mem_wkey    = key_r;
            mem_whandle = handle_r;
            count_nxt   = count_r + CntW'(1);
          end else begin
            status_nxt = STS_NOT_FOUND;
          end
        end else begin
          rd_idx_nxt  = rd_idx_r + CntW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IdxW-1:0];
        end
      end
      ST_SHIFT: begin
        // Data read for index i lands in the next cycle and is written to i - 1.
        mem_we = cmp_vld_r;
        if (scan_done) begin
          cmp_vld_nxt = 1'b0;
          count_nxt   = count_r - CntW'(1);
        end else begin
          rd_idx_nxt  = rd_idx_r + CntW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IdxW-1:0];
        end
      end
      ST_READ: begin
        fhandle_nxt = mem_rhandle;
        fkey_nxt    = mem_rkey;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    handle_r  <= handle_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    status_r  <= status_nxt;
    fhandle_r <= fhandle_nxt;
    fkey_r    <= fkey_nxt;
    fpos_r    <= fpos_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SEARCH || state_r == ST_SHIFT))
    else $error("memory written outside search or shift");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_SEARCH) |=> count_r == $past(count_r) + CntW'(1))
    else $error("append did not grow the entry count");

  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && state_nxt == ST_RESP)
      |=> count_r == $past(count_r) - CntW'(1))
    else $error("delete did not shrink the entry count");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && !res_ready) |=> state_r == ST_RESP && $stable(count_r))
    else $error("result left before it was taken");
`endif

endmodule

`default_nettype wire

[tb/tb_unique_key_list_table.sv]
// Self-checking testbench for the unique-key list table with a request driver and result monitor.
`timescale 1ns / 100ps

module tb_unique_key_list_table;
  import ukl_pkg::*;

  localparam int TABLE_DEPTH = UKL_TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
  localparam int POOL_SIZE = 24;

  typedef struct {
    ukl_op_t     op;
    logic [31:0] key;
    logic [15:0] handle;
    logic [7:0]  pos;
    bit          drain_first;
  } table_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_song_key = '0;
  logic [15:0] in_song_handle = '0;
  logic [7:0]  in_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_found_handle;
  logic [31:0] out_found_key;
  logic [7:0]  out_found_position;
  logic [8:0]  out_entry_total;

  // Shadow copy of the table, updated as each request is accepted.
  logic [31:0] tbl_key [TABLE_DEPTH];
  logic [15:0] tbl_handle [TABLE_DEPTH];
  int          tbl_count = 0;
  int          tbl_peak = 0;

  table_req_t  req_backlog[$];
  ukl_result_t answers_due[$];
  logic [31:0] key_pool [POOL_SIZE];
  table_req_t  head_req;

  int driven_cnt = 0;
  int accepted_cnt = 0;
  int answered_cnt = 0;
  int burst_left = 4;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;
  int cycle_cnt = 0;
  int errors = 0;
  int op_seen [4] = '{default: 0};
  int status_seen [5] = '{default: 0};

  unique_key_list_table i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_song_key        (in_song_key),
    .in_song_handle     (in_song_handle),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_handle   (out_found_handle),
    .out_found_key      (out_found_key),
    .out_found_position (out_found_position),
    .out_entry_total    (out_entry_total)
  );

  always #1 clk = ~clk;

  // Applies one request to the shadow table and returns the answer the block owes.
  function automatic ukl_result_t table_answer(ukl_op_t op, logic [31:0] key,
                                               logic [15:0] handle, logic [7:0] pos);
    ukl_result_t r;
    int hit;
    r = '0;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == key) begin
        hit = i;
        break;
      end
    end
    case (op)
      OP_LOOKUP, OP_DELETE: begin
        if (hit >= 0) begin
          r.status = STS_OK;
          r.found_handle = tbl_handle[hit];
          r.found_key = tbl_key[hit];
          r.found_position = hit[7:0];
          if (op == OP_DELETE) begin
            for (int j = hit; j + 1 < tbl_count; j++) begin
              tbl_key[j] = tbl_key[j + 1];
              tbl_handle[j] = tbl_handle[j + 1];
            end
            tbl_count--;
          end
        end else begin
          r.status = STS_NOT_FOUND;
        end
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          r.status = STS_DUPLICATE;
          r.found_handle = tbl_handle[hit];
          r.found_key = tbl_key[hit];
          r.found_position = hit[7:0];
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          r.status = STS_OK;
          tbl_key[tbl_count] = key;
          tbl_handle[tbl_count] = handle;
          tbl_count++;
        end
      end
      default: begin
        if (int'(pos) < tbl_count) begin
          r.status = STS_OK;
          r.found_handle = tbl_handle[pos];
          r.found_key = tbl_key[pos];
          r.found_position = pos;
        end else begin
          r.status = STS_RANGE;
        end
      end
    endcase
    r.entry_total = tbl_count[8:0];
    if (tbl_count > tbl_peak) tbl_peak = tbl_count;
    op_seen[op]++;
    status_seen[r.status]++;
    return r;
  endfunction

  function automatic logic [31:0] fill_key(int idx);
    return {8'hA5, 8'(idx), 16'hC35A};
  endfunction

  // Draws a key that is likely to hit either the small pool or the fill keys.
  function automatic logic [31:0] draw_key(int pool_pct, int fill_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < pool_pct) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (pick < pool_pct + fill_pct) return fill_key($urandom_range(0, 255));
    return $urandom;
  endfunction

  task automatic queue_req(ukl_op_t op, logic [31:0] key, logic [15:0] handle,
                           logic [7:0] pos, bit drain_first = 1'b0);
    table_req_t r;
    r.op = op;
    r.key = key;
    r.handle = handle;
    r.pos = pos;
    r.drain_first = drain_first;
    req_backlog.push_back(r);
  endtask

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      flag_error($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                           answered_cnt, name, want, got));
  endtask

  // Request driver: bursts of requests separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && accepted_cnt != driven_cnt) begin
      // Request still waiting for in_ready; hold it.
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (req_backlog.size() == 0 ||
                 (req_backlog[0].drain_first && answers_due.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      head_req = req_backlog.pop_front();
      in_valid <= 1'b1;
      in_opcode <= head_req.op;
      in_song_key <= head_req.key;
      in_song_handle <= head_req.handle;
      in_position <= head_req.pos;
      driven_cnt <= driven_cnt + 1;
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Result receiver: switches between always ready, random stalls and a sparse pattern.
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_phase <= $urandom_range(50, 200);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (stall_phase % 5 == 0);
    endcase
  end

  // Monitor: checks each result against the oldest owed answer, then records new requests.
  always @(posedge clk) begin
    ukl_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          flag_error($sformatf("result with no request outstanding, status %0d", out_status));
        end else begin
          want = answers_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("found_handle", 32'(want.found_handle), 32'(out_found_handle));
          check_field("found_key", want.found_key, out_found_key);
          check_field("found_position", 32'(want.found_position), 32'(out_found_position));
          check_field("entry_total", 32'(want.entry_total), 32'(out_entry_total));
        end
        answered_cnt <= answered_cnt + 1;
      end
      if (in_valid && in_ready) begin
        answers_due.push_back(table_answer(ukl_op_t'(in_opcode), in_song_key,
                                           in_song_handle, in_position));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_cnt, answers_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int pick;
    ukl_op_t op;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Directed part: empty table, extreme keys and handles, duplicates, compaction.
    queue_req(OP_READ, 32'h0, 16'h0, 8'd0);
    queue_req(OP_LOOKUP, 32'hDEAD_BEEF, 16'h0, 8'd0);
    queue_req(OP_DELETE, 32'hDEAD_BEEF, 16'h0, 8'd0);
    queue_req(OP_INSERT, 32'h0000_0000, 16'h0000, 8'hFF);
    queue_req(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
    queue_req(OP_INSERT, 32'h0000_0000, 16'h1234, 8'd0);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    queue_req(OP_LOOKUP, 32'h0000_0000, 16'h0, 8'd0);
    queue_req(OP_READ, 32'h0, 16'h0, 8'd0);
    queue_req(OP_READ, 32'h0, 16'h0, 8'd1);
    queue_req(OP_READ, 32'h0, 16'h0, 8'd2);
    queue_req(OP_READ, 32'hFFFF_FFFF, 16'hFFFF, 8'd255);
    queue_req(OP_INSERT, 32'h1234_5678, 16'hA5A5, 8'd0);
    queue_req(OP_INSERT, 32'h8765_4321, 16'h5A5A, 8'd0);
    // Deleting the first entry moves every later entry down one place.
    queue_req(OP_DELETE, 32'h0000_0000, 16'h0, 8'd0);
    queue_req(OP_READ, 32'h0, 16'h0, 8'd0);
    queue_req(OP_READ, 32'h0, 16'h0, 8'd2);
    queue_req(OP_LOOKUP, 32'h0000_0000, 16'h0, 8'd0);
    queue_req(OP_DELETE, 32'h8765_4321, 16'h0, 8'd0);
    queue_req(OP_DELETE, 32'h8765_4321, 16'h0, 8'd0);
    queue_req(OP_INSERT, 32'hFFFF_FFFF, 16'h0000, 8'd0);
    queue_req(OP_LOOKUP, 32'h1234_5678, 16'h0, 8'd0);

    // Random traffic on a small key pool so hits, duplicates and misses all occur.
    for (int n = 0; n < 250; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_INSERT;
      else if (pick < 55) op = OP_LOOKUP;
      else if (pick < 80) op = OP_DELETE;
      else op = OP_READ;
      queue_req(op, draw_key(80, 0), 16'($urandom_range(0, 65535)),
                ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 23))
                                           : 8'($urandom_range(0, 255)),
                n == 120);
    end

    // Fill the table to capacity, then run past it so the full case is reached.
    for (int n = 0; n < TABLE_DEPTH + 4; n++)
      queue_req(OP_INSERT, (n < 256) ? fill_key(n) : {8'hA6, 8'(n), 16'h3C3C},
                16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), n == 0);
    queue_req(OP_INSERT, fill_key(7), 16'hBEEF, 8'd0);
    queue_req(OP_READ, 32'h0, 16'h0, 8'd255);
    queue_req(OP_LOOKUP, fill_key(255), 16'h0, 8'd0);
    queue_req(OP_READ, 32'h0, 16'h0, 8'd0);
    queue_req(OP_DELETE, 32'h0000_0000, 16'h0, 8'd0);
    queue_req(OP_DELETE, fill_key(0), 16'h0, 8'd0);
    queue_req(OP_INSERT, 32'hC001_D00D, 16'hFFFF, 8'd0);
    queue_req(OP_INSERT, 32'hC001_D00E, 16'h0001, 8'd0);

    // Random traffic on a large table, mostly deletes and reads with long searches.
    for (int n = 0; n < 130; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) op = OP_INSERT;
      else if (pick < 40) op = OP_LOOKUP;
      else if (pick < 75) op = OP_DELETE;
      else op = OP_READ;
      queue_req(op, draw_key(20, 70), 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255)));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || accepted_cnt != driven_cnt || answers_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d lookups, %0d inserts, %0d deletes, %0d reads);",
             accepted_cnt, op_seen[OP_LOOKUP], op_seen[OP_INSERT], op_seen[OP_DELETE],
             op_seen[OP_READ]);
    $display("outcomes %0d ok, %0d miss, %0d dup, %0d full, %0d range; peak %0d entries.",
             status_seen[STS_OK], status_seen[STS_NOT_FOUND], status_seen[STS_DUPLICATE],
             status_seen[STS_FULL], status_seen[STS_RANGE], tbl_peak);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d errors in total.", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ukl_pkg.sv
sv/ukl_mem.sv
sv/ukl_ctrl.sv
sv/unique_key_list_table.sv
tb/tb_unique_key_list_table.sv
